### rtl/lcrp_pkg.sv
// Package: shared constants and types for the loop capture reverse playback unit.
`timescale 1ns / 1ps
package lcrp_pkg;
    localparam int MAX_LOOP_SAMPLES = 65536;
    localparam int SAMPLE_BITS      = 24;
    localparam int ADDR_BITS        = $clog2(MAX_LOOP_SAMPLES);
    localparam int LEN_BITS         = 17;
    localparam int TIME_BITS        = 48;
    localparam int MIX_BITS         = 16;
    localparam int ENTRY_BITS       = 2 * SAMPLE_BITS;
    localparam logic [MIX_BITS-1:0] MIX_ONE = 16'd32768;

    // Item handed from the front part to the back part.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] dry_l;
        logic signed [SAMPLE_BITS-1:0] dry_r;
        logic [MIX_BITS-1:0]           mix;
        logic                          do_write;
        logic [ADDR_BITS-1:0]          waddr;
        logic                          do_read;
        logic [TIME_BITS:0]            elapsed;  // now - origin, signed, one bit wider
        logic [LEN_BITS-1:0]           len;
        logic                          capturing;
        logic                          loop_ready;
        logic                          capture_done;
    } lcrp_cmd_t;
endpackage

### rtl/lcrp_ram.sv
// Generic single port RAM with registered read.
`timescale 1ns / 1ps
module lcrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### rtl/lcrp_front.sv
// Front part: transport and capture control, one item per cycle while the command queue is not full.
`timescale 1ns / 1ps
module lcrp_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [lcrp_pkg::LEN_BITS-1:0]       capture_length,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [lcrp_pkg::SAMPLE_BITS-1:0] left_in,
    input  logic signed [lcrp_pkg::SAMPLE_BITS-1:0] right_in,
    input  logic [lcrp_pkg::MIX_BITS-1:0]       mix_level,
    input  logic                                host_playing,
    input  logic [lcrp_pkg::TIME_BITS-1:0]      sample_time,
    input  logic                                arm_request,
    input  logic                                disarm_request,
    input  logic                                start_allowed,
    input  logic                                playback_stopped,
    output logic                                cmd_valid,
    input  logic                                cmd_full,
    output lcrp_pkg::lcrp_cmd_t                 cmd
);
    import lcrp_pkg::*;

    logic                 armed_reg, armed_next;
    logic                 active_reg, active_next;
    logic                 pending_reg, pending_next;
    logic                 held_reg, held_next;
    logic [LEN_BITS-1:0]  widx_reg, widx_next;
    logic [TIME_BITS-1:0] origin_reg, origin_next;
    logic [LEN_BITS-1:0]  len;
    logic                 fire;

    assign in_stall  = cmd_full;
    assign fire      = in_valid && !cmd_full;
    assign cmd_valid = fire;

    always_comb
    begin
        len = capture_length;
        if (capture_length == '0)
        begin
            len = LEN_BITS'(1);
        end
        else if (capture_length > LEN_BITS'(MAX_LOOP_SAMPLES))
        begin
            len = LEN_BITS'(MAX_LOOP_SAMPLES);
        end
    end

    always_comb
    begin
        armed_next   = armed_reg;
        active_next  = active_reg;
        pending_next = pending_reg;
        held_next    = held_reg;
        widx_next    = widx_reg;
        origin_next  = origin_reg;
        cmd          = '0;
        cmd.dry_l    = left_in;
        cmd.dry_r    = right_in;
        cmd.mix      = (mix_level > MIX_ONE) ? MIX_ONE : mix_level;
        cmd.len      = len;
        if (arm_request)
        begin
            armed_next = 1'b1;
            if (host_playing)
            begin
                pending_next = 1'b1;
            end
        end
        if (disarm_request)
        begin
            armed_next = 1'b0;
        end
        if (playback_stopped && armed_next && !active_next)
        begin
            armed_next = 1'b0;
            widx_next  = '0;
        end
        if ((playback_stopped || !armed_next) && active_next)
        begin
            armed_next  = 1'b0;
            active_next = 1'b0;
            widx_next   = '0;
            origin_next = '0;
            held_next   = 1'b0;
        end
        if (armed_next && !active_next && (start_allowed || pending_next))
        begin
            held_next    = 1'b0;
            widx_next    = '0;
            origin_next  = sample_time;
            active_next  = 1'b1;
            pending_next = 1'b0;
        end
        if (armed_next && active_next)
        begin
            // drop writes past the end of the store
            cmd.do_write = (widx_next < LEN_BITS'(MAX_LOOP_SAMPLES));
            cmd.waddr    = widx_next[ADDR_BITS-1:0];
            widx_next    = widx_next + LEN_BITS'(1);
            if (widx_next >= len)
            begin
                armed_next   = 1'b0;
                active_next  = 1'b0;
                widx_next    = '0;
                origin_next  = origin_next + TIME_BITS'(len);
                held_next    = 1'b1;
                cmd.capture_done = 1'b1;
            end
        end
        cmd.do_read    = held_next && host_playing;
        cmd.elapsed    = {1'b0, sample_time} - {1'b0, origin_next};
        cmd.capturing  = active_next;
        cmd.loop_ready = held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            active_reg  <= 1'b0;
            pending_reg <= 1'b0;
            held_reg    <= 1'b0;
            widx_reg    <= '0;
            origin_reg  <= '0;
        end
        else if (fire)
        begin
            armed_reg   <= armed_next;
            active_reg  <= active_next;
            pending_reg <= pending_next;
            held_reg    <= held_next;
            widx_reg    <= widx_next;
            origin_reg  <= origin_next;
        end
    end

    a_active_not_held: assert property (@(posedge clk) disable iff (!rst_n)
        !(active_reg && held_reg)) else $error("capture active while loop held");
    a_active_armed: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> armed_reg) else $error("capture active without arm");
    a_widx_range: assert property (@(posedge clk) disable iff (!rst_n)
        widx_reg <= LEN_BITS'(MAX_LOOP_SAMPLES)) else $error("write index out of range");
endmodule

### rtl/lcrp_back.sv
// Back part: command queue, serial modulo, store access and wet/dry mix.
`timescale 1ns / 1ps
module lcrp_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_full,
    input  lcrp_pkg::lcrp_cmd_t                 cmd,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [lcrp_pkg::SAMPLE_BITS-1:0] left_out,
    output logic signed [lcrp_pkg::SAMPLE_BITS-1:0] right_out,
    output logic                                capturing,
    output logic                                loop_ready,
    output logic                                capture_done
);
    import lcrp_pkg::*;

    localparam int QDEPTH = 2;
    localparam int MODW   = TIME_BITS + 1;
    localparam int DW     = SAMPLE_BITS + 1;
    localparam int PW     = DW + MIX_BITS + 1;

    typedef enum logic [2:0] {S_IDLE, S_MOD, S_RAM, S_RDATA, S_MUL, S_OUT} state_t;

    lcrp_cmd_t q_reg [QDEPTH];
    logic      wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic      pop;

    state_t               state_reg;
    lcrp_cmd_t            cur_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic [TIME_BITS-1:0] quo_reg;
    logic [5:0]           bit_reg;
    logic                 neg_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic signed [PW-1:0] pl_reg, pr_reg;
    logic [ENTRY_BITS-1:0] rdata;
    logic signed [SAMPLE_BITS-1:0] wet_l_reg, wet_r_reg;

    logic [MODW-1:0]      trial;
    logic [TIME_BITS-1:0] rem_shift;
    logic [LEN_BITS-1:0]  fwd;
    logic [LEN_BITS-1:0]  rev;
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_addr;

    assign cmd_full = (count_reg == 2'd2);
    assign pop      = (state_reg == S_IDLE) && (count_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (cmd_valid)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(cmd_valid) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid)
        begin
            q_reg[wr_ptr_reg] <= cmd;
        end
    end

    // one quotient bit per cycle of |elapsed| mod len (restoring division)
    always_comb
    begin
        rem_shift = {rem_reg[TIME_BITS-2:0], quo_reg[TIME_BITS-1]};
        trial     = {rem_reg, quo_reg[TIME_BITS-1]} - MODW'(cur_reg.len);
    end

    always_comb
    begin
        if (!neg_reg || rem_reg == '0)
        begin
            fwd = rem_reg[LEN_BITS-1:0];
        end
        else
        begin
            fwd = cur_reg.len - rem_reg[LEN_BITS-1:0];
        end
        rev = cur_reg.len - LEN_BITS'(1) - fwd;
    end

    assign ram_we   = (state_reg == S_IDLE) && pop && q_reg[rd_ptr_reg].do_write;
    assign ram_addr = (state_reg == S_IDLE) ? q_reg[rd_ptr_reg].waddr : addr_reg;

    lcrp_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_LOOP_SAMPLES)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ({q_reg[rd_ptr_reg].dry_r, q_reg[rd_ptr_reg].dry_l}),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            out_valid    <= 1'b0;
            capturing    <= 1'b0;
            loop_ready   <= 1'b0;
            capture_done <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        cur_reg <= q_reg[rd_ptr_reg];
                        neg_reg <= q_reg[rd_ptr_reg].elapsed[TIME_BITS];
                        quo_reg <= q_reg[rd_ptr_reg].elapsed[TIME_BITS]
                                   ? TIME_BITS'(-q_reg[rd_ptr_reg].elapsed)
                                   : q_reg[rd_ptr_reg].elapsed[TIME_BITS-1:0];
                        rem_reg <= '0;
                        bit_reg <= '0;
                        state_reg <= q_reg[rd_ptr_reg].do_read ? S_MOD : S_MUL;
                    end
                end
                S_MOD:
                begin
                    rem_reg <= trial[MODW-1] ? rem_shift : trial[TIME_BITS-1:0];
                    quo_reg <= {quo_reg[TIME_BITS-2:0], 1'b0};
                    bit_reg <= bit_reg + 6'd1;
                    if (bit_reg == 6'(TIME_BITS - 1))
                    begin
                        state_reg <= S_RAM;
                    end
                end
                S_RAM:
                begin
                    addr_reg  <= rev[ADDR_BITS-1:0];
                    state_reg <= S_RDATA;
                end
                S_RDATA:
                begin
                    // read is registered: data valid in the cycle after the address
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    wet_l_reg <= cur_reg.do_read ? rdata[SAMPLE_BITS-1:0] : cur_reg.dry_l;
                    wet_r_reg <= cur_reg.do_read ? rdata[ENTRY_BITS-1:SAMPLE_BITS]
                                                 : cur_reg.dry_r;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid || !out_stall)
                    begin
                        pl_reg <= PW'($signed({1'b0, cur_reg.mix}))
                                  * PW'(DW'(wet_l_reg) - DW'(cur_reg.dry_l))
                                  + PW'(16384);
                        pr_reg <= PW'($signed({1'b0, cur_reg.mix}))
                                  * PW'(DW'(wet_r_reg) - DW'(cur_reg.dry_r))
                                  + PW'(16384);
                        out_valid    <= 1'b1;
                        capturing    <= cur_reg.capturing;
                        loop_ready   <= cur_reg.loop_ready;
                        capture_done <= cur_reg.capture_done;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (out_valid && !out_stall && !(state_reg == S_OUT))
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // floor shift implements round half up after the bias
    logic signed [PW-1:0] ql, qr;
    assign ql = pl_reg >>> 15;
    assign qr = pr_reg >>> 15;
    logic signed [SAMPLE_BITS-1:0] dry_l_out_reg, dry_r_out_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!out_valid || !out_stall))
        begin
            dry_l_out_reg <= cur_reg.dry_l;
            dry_r_out_reg <= cur_reg.dry_r;
        end
    end
    assign left_out  = dry_l_out_reg + ql[SAMPLE_BITS-1:0];
    assign right_out = dry_r_out_reg + qr[SAMPLE_BITS-1:0];

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2) else $error("queue overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_full |-> !cmd_valid) else $error("push into full queue");
    a_mod_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RAM) |-> (rem_reg < TIME_BITS'(cur_reg.len)))
        else $error("remainder not below length");
endmodule

### rtl/loop_capture_reverse_playback_unit.sv
// Top level: loop capture with reverse playback, front control and back datapath.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-------------------------------------------
//  input     | in_valid / in_stall     | left_in right_in mix_level flags sample_time
//  output    | out_valid / out_stall   | left_out right_out capturing loop_ready done
//  config    | cfg_valid / cfg_ready   | cfg_data (capture_length)
//
// An item with no loop playing passes the idle, mix and output states; reading
// the reversed store adds the bit-serial 48-bit modulo, which dominates, and the
// address and read states. A two-entry queue sits between control and datapath.
// Reset clears all control state; store contents are undefined until captured.
// A stalled output holds; input stalls when the queue is full.
`timescale 1ns / 1ps
module loop_capture_reverse_playback_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lcrp_pkg::LEN_BITS-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [lcrp_pkg::SAMPLE_BITS-1:0] left_in,
    input  logic signed [lcrp_pkg::SAMPLE_BITS-1:0] right_in,
    input  logic [lcrp_pkg::MIX_BITS-1:0]       mix_level,
    input  logic                                host_playing,
    input  logic [lcrp_pkg::TIME_BITS-1:0]      sample_time,
    input  logic                                arm_request,
    input  logic                                disarm_request,
    input  logic                                start_allowed,
    input  logic                                playback_stopped,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [lcrp_pkg::SAMPLE_BITS-1:0] left_out,
    output logic signed [lcrp_pkg::SAMPLE_BITS-1:0] right_out,
    output logic                                capturing,
    output logic                                loop_ready,
    output logic                                capture_done
);
    import lcrp_pkg::*;

    logic [LEN_BITS-1:0] len_reg;
    logic                cmd_valid;
    logic                cmd_full;
    lcrp_cmd_t           cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_BITS'(MAX_LOOP_SAMPLES);
        end
        else if (cfg_valid)
        begin
            len_reg <= cfg_data;
        end
    end

    lcrp_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .capture_length   (len_reg),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .left_in          (left_in),
        .right_in         (right_in),
        .mix_level        (mix_level),
        .host_playing     (host_playing),
        .sample_time      (sample_time),
        .arm_request      (arm_request),
        .disarm_request   (disarm_request),
        .start_allowed    (start_allowed),
        .playback_stopped (playback_stopped),
        .cmd_valid        (cmd_valid),
        .cmd_full         (cmd_full),
        .cmd              (cmd)
    );

    lcrp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_full     (cmd_full),
        .cmd          (cmd),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_out     (left_out),
        .right_out    (right_out),
        .capturing    (capturing),
        .loop_ready   (loop_ready),
        .capture_done (capture_done)
    );
endmodule

### sim/lcrp_scoreboard.sv
// Checker: predicts each mixed output sample and compares it with the block's results.
`timescale 1ns / 1ps
module lcrp_scoreboard (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [lcrp_pkg::LEN_BITS-1:0]       cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [lcrp_pkg::SAMPLE_BITS-1:0] left_in,
    input  logic signed [lcrp_pkg::SAMPLE_BITS-1:0] right_in,
    input  logic [lcrp_pkg::MIX_BITS-1:0]       mix_level,
    input  logic                                host_playing,
    input  logic [lcrp_pkg::TIME_BITS-1:0]      sample_time,
    input  logic                                arm_request,
    input  logic                                disarm_request,
    input  logic                                start_allowed,
    input  logic                                playback_stopped,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [lcrp_pkg::SAMPLE_BITS-1:0] left_out,
    input  logic signed [lcrp_pkg::SAMPLE_BITS-1:0] right_out,
    input  logic                                capturing,
    input  logic                                loop_ready,
    input  logic                                capture_done,
    output int                                  pending,
    output int                                  errors
);
    import lcrp_pkg::*;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic                          capturing;
        logic                          loop_ready;
        logic                          capture_done;
    } mixed_sample_t;

    mixed_sample_t          mixed_q[$];
    logic [LEN_BITS-1:0]    loop_len_reg;
    bit                     armed, active, start_pend, held;
    int unsigned            wr_idx;
    logic [TIME_BITS-1:0]   origin;
    logic [ENTRY_BITS-1:0]  take_store [0:MAX_LOOP_SAMPLES-1];

    assign pending = mixed_q.size();

    function automatic logic signed [SAMPLE_BITS-1:0] blend(longint dry, longint wet,
                                                             int unsigned mix);
        longint p;
        p = longint'(mix) * (wet - dry) + 16384;
        return SAMPLE_BITS'(dry + (p >>> 15));
    endfunction

    function automatic void drop_take();
        armed  = 0;
        active = 0;
        wr_idx = 0;
        origin = '0;
        held   = 0;
    endfunction

    task automatic predict_sample();
        mixed_sample_t s;
        int unsigned   len, mix, rev;
        longint        d, wet_l, wet_r, fwd, r;
        bit            done;
        len = loop_len_reg;
        if (len < 1) len = 1;
        if (len > MAX_LOOP_SAMPLES) len = MAX_LOOP_SAMPLES;
        mix = mix_level > MIX_ONE ? MIX_ONE : mix_level;
        wet_l = left_in;
        wet_r = right_in;
        done = 0;
        if (arm_request) begin
            armed = 1;
            if (host_playing) start_pend = 1;
        end
        if (disarm_request) armed = 0;
        if (playback_stopped && armed && !active) begin
            armed  = 0;
            wr_idx = 0;
        end
        if (playback_stopped && active) drop_take();
        if (!armed && active) drop_take();
        if (armed && !active && (start_allowed || start_pend)) begin
            held       = 0;
            wr_idx     = 0;
            origin     = sample_time;
            active     = 1;
            start_pend = 0;
        end
        if (armed && active) begin
            if (wr_idx < MAX_LOOP_SAMPLES) take_store[wr_idx] = {right_in, left_in};
            wr_idx++;
            if (wr_idx >= len) begin
                armed  = 0;
                active = 0;
                wr_idx = 0;
                origin = origin + TIME_BITS'(len);
                held   = 1;
                done   = 1;
            end
        end
        if (held && host_playing) begin
            d = longint'(sample_time) - longint'(origin);
            if (d >= 0) fwd = d % len;
            else begin
                r = (-d) % len;
                fwd = r != 0 ? len - r : 0;
            end
            rev = len - 1 - int'(fwd);
            wet_l = $signed(take_store[rev][SAMPLE_BITS-1:0]);
            wet_r = $signed(take_store[rev][ENTRY_BITS-1:SAMPLE_BITS]);
        end
        s.left         = blend(left_in, wet_l, mix);
        s.right        = blend(right_in, wet_r, mix);
        s.capturing    = active;
        s.loop_ready   = held;
        s.capture_done = done;
        mixed_q.push_back(s);
    endtask

    always @(posedge clk or negedge rst_n) begin
        mixed_sample_t exp_s;
        if (!rst_n) begin
            loop_len_reg <= 17'd65536;
            drop_take();
            start_pend = 0;
            errors <= 0;
            mixed_q.delete();
        end
        else begin
            if (cfg_valid && cfg_ready) loop_len_reg <= cfg_data;
            if (in_valid && !in_stall) predict_sample();
            if (out_valid && !out_stall) begin
                if (mixed_q.size() == 0) begin
                    $error("result with no expected sample");
                    errors <= errors + 1;
                end
                else begin
                    exp_s = mixed_q.pop_front();
                    if (left_out !== exp_s.left || right_out !== exp_s.right
                        || capturing !== exp_s.capturing || loop_ready !== exp_s.loop_ready
                        || capture_done !== exp_s.capture_done)
                        errors <= errors + 1;
                    if (left_out !== exp_s.left)
                        $error("left_out: expected %0d, got %0d", exp_s.left, left_out);
                    if (right_out !== exp_s.right)
                        $error("right_out: expected %0d, got %0d", exp_s.right, right_out);
                    if (capturing !== exp_s.capturing)
                        $error("capturing: expected %0b, got %0b", exp_s.capturing, capturing);
                    if (loop_ready !== exp_s.loop_ready)
                        $error("loop_ready: expected %0b, got %0b", exp_s.loop_ready,
                               loop_ready);
                    if (capture_done !== exp_s.capture_done)
                        $error("capture_done: expected %0b, got %0b", exp_s.capture_done,
                               capture_done);
                end
            end
        end
    end
endmodule

### sim/loop_capture_reverse_playback_unit_tb.sv
// Testbench top: drives samples and loop lengths into the unit and reports the verdict.
`timescale 1ns / 1ps
module loop_capture_reverse_playback_unit_tb;
    import lcrp_pkg::*;

    logic                          clk, rst_n;
    logic                          cfg_valid, cfg_ready;
    logic [LEN_BITS-1:0]           cfg_data;
    logic                          in_valid, in_stall;
    logic signed [SAMPLE_BITS-1:0] left_in, right_in;
    logic [MIX_BITS-1:0]           mix_level;
    logic                          host_playing;
    logic [TIME_BITS-1:0]          sample_time;
    logic                          arm_request, disarm_request, start_allowed;
    logic                          playback_stopped;
    logic                          out_valid, out_stall;
    logic signed [SAMPLE_BITS-1:0] left_out, right_out;
    logic                          capturing, loop_ready, capture_done;
    int                            pending, errors;
    int                            send_gap_pct, recv_stall_pct;
    logic [TIME_BITS-1:0]          timeline;
    logic [LEN_BITS-1:0]           cur_len;

    localparam logic [LEN_BITS-1:0] PHASE_LEN [0:6] =
        '{17'd5, 17'd0, 17'd64, 17'd65536, 17'd23, 17'd131071, 17'd1};

    loop_capture_reverse_playback_unit u_dut (.*);

    lcrp_scoreboard u_scoreboard (.*);

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("loop_capture_reverse_playback_unit regression: fail");
        $finish;
    end

    always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

    function automatic int unsigned eff_len(logic [LEN_BITS-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_LOOP_SAMPLES) return MAX_LOOP_SAMPLES;
        return v;
    endfunction

    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] l, r,
                               logic [MIX_BITS-1:0] mix, logic play,
                               logic [TIME_BITS-1:0] t, logic arm, disarm, allow, stop);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_gap_pct) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        left_in          <= l;
        right_in         <= r;
        mix_level        <= mix;
        host_playing     <= play;
        sample_time      <= t;
        arm_request      <= arm;
        disarm_request   <= disarm;
        start_allowed    <= allow;
        playback_stopped <= stop;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_random();
        logic [MIX_BITS-1:0] mix;
        case ($urandom_range(9))
            0: mix = 16'd0;
            1: mix = MIX_ONE;
            2: mix = 16'($urandom);
            default: mix = 16'($urandom_range(32768));
        endcase
        // mostly advance one sample; now and then jump anywhere on the timeline or step back by up to 200
        case ($urandom_range(99))
            0, 1, 2: timeline = {16'($urandom), 32'($urandom)};
            3, 4:    timeline = timeline - TIME_BITS'($urandom_range(200));
            default: timeline = timeline + 1;
        endcase
        send_sample(24'($urandom), 24'($urandom), mix, $urandom_range(99) < 85, timeline,
                    $urandom_range(24) == 0, $urandom_range(59) == 0,
                    $urandom_range(7) == 0, $urandom_range(49) == 0);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_len(logic [LEN_BITS-1:0] v);
        bit raise;
        raise = eff_len(v) > eff_len(cur_len) && eff_len(v) > 1;
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_len = v;
        // drop any held loop so a longer length never reads unwritten entries
        if (raise) begin
            send_sample(24'd1, -24'sd1, 16'd0, 1'b0, timeline, 1'b1, 1'b0, 1'b1, 1'b0);
            send_sample(24'd2, -24'sd2, 16'd0, 1'b0, timeline, 1'b0, 1'b1, 1'b0, 1'b0);
            settle();
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        {left_in, right_in, mix_level, sample_time} = '0;
        {host_playing, arm_request, disarm_request, start_allowed, playback_stopped} = '0;
        out_stall = 1'b0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        timeline = '0;
        cur_len = 17'd65536;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // passthrough at full length, sample and mix extremes
        send_sample(24'h7FFFFF, 24'h800000, 16'd0, 1'b1, 48'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_sample(24'h800000, 24'h7FFFFF, MIX_ONE, 1'b1, 48'hFFFF_FFFF_FFFF,
                    1'b0, 1'b0, 1'b0, 1'b0);
        send_sample(24'h000001, 24'hFFFFFF, 16'hFFFF, 1'b0, 48'd7, 1'b0, 1'b0, 1'b1, 1'b1);
        // arm while playing: pending start, then disarm mid-capture clears
        send_sample(24'd100, 24'd200, 16'd16384, 1'b1, 48'd10, 1'b1, 1'b0, 1'b0, 1'b0);
        send_sample(24'd101, 24'd201, 16'd16384, 1'b1, 48'd11, 1'b0, 1'b1, 1'b0, 1'b0);
        // arm and disarm together, then stop while armed but idle
        send_sample(24'd5, 24'd6, 16'd1, 1'b0, 48'd12, 1'b1, 1'b1, 1'b1, 1'b0);
        send_sample(24'd5, 24'd6, 16'd1, 1'b0, 48'd13, 1'b1, 1'b0, 1'b0, 1'b1);
        // start, then stop mid-capture
        send_sample(24'd7, 24'd8, 16'd2, 1'b1, 48'd14, 1'b1, 1'b0, 1'b1, 1'b0);
        send_sample(24'd7, 24'd8, 16'd2, 1'b0, 48'd15, 1'b0, 1'b0, 1'b0, 1'b1);
        settle();
        write_len(17'd1);
        // one-sample loop, then reversed playback with extreme times and mixes
        send_sample(24'h7FFFFF, 24'h800000, MIX_ONE, 1'b1, 48'd50, 1'b1, 1'b0, 1'b1, 1'b0);
        send_sample(24'h800000, 24'h7FFFFF, MIX_ONE, 1'b1, 48'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_sample(24'h800000, 24'h7FFFFF, 16'hFFFF, 1'b1, 48'hFFFF_FFFF_FFFF,
                    1'b0, 1'b0, 1'b0, 1'b0);
        send_sample(24'h000000, 24'h000001, 16'd16385, 1'b1, 48'd3, 1'b0, 1'b0, 1'b0, 1'b0);
        send_sample(24'hFFFFFF, 24'h000000, 16'd1, 1'b1, 48'd4, 1'b0, 1'b0, 1'b0, 1'b0);
        settle();
        write_len(17'd4);
        // four-sample loop, time behind the origin, then length cut mid-capture
        for (int i = 0; i < 6; i++)
            send_sample(24'(i * 1000), 24'(-i * 1000), 16'd32767, 1'b1, 48'd100 + i,
                        i == 0, 1'b0, i == 0, 1'b0);
        send_sample(24'd9, 24'd9, MIX_ONE, 1'b1, 48'd90, 1'b0, 1'b0, 1'b0, 1'b0);
        send_sample(24'd9, 24'd9, MIX_ONE, 1'b1, 48'd200, 1'b1, 1'b0, 1'b1, 1'b0);
        settle();
        write_len(17'd2);
        send_sample(24'd3, 24'd3, MIX_ONE, 1'b1, 48'd201, 1'b0, 1'b0, 1'b0, 1'b0);
        settle();

        for (int p = 0; p < 7; p++) begin
            send_gap_pct   = p < 2 ? 20 : (p < 4 ? 60 : 0);
            recv_stall_pct = p < 2 ? 60 : (p < 4 ? 20 : 0);
            write_len(PHASE_LEN[p]);
            for (int n = 0; n < 270; n++) begin
                send_random();
                if (p == 2 && n == 100) begin
                    in_valid <= 1'b0;
                    do @(posedge clk); while (pending != 0);
                end
            end
            settle();
        end

        if (errors == 0)
            $display("loop_capture_reverse_playback_unit regression: pass");
        else
            $display("loop_capture_reverse_playback_unit regression: fail");
        $finish;
    end
endmodule

### sim.f
rtl/lcrp_pkg.sv
rtl/lcrp_ram.sv
rtl/lcrp_front.sv
rtl/lcrp_back.sv
rtl/loop_capture_reverse_playback_unit.sv
sim/lcrp_scoreboard.sv
sim/loop_capture_reverse_playback_unit_tb.sv
